/* hdl/bpof_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpof_pkg;

  // Largest pattern the datapath can be built for, and the defaults.
  localparam int PATTERN_LIMIT       = 16;
  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Fixed field widths.
  localparam int BYTE_BITS      = 8;
  localparam int LEN_BITS       = 5;
  localparam int PAT_IDX_BITS   = 4;
  localparam int MATCH_OFS_BITS = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_reg_e;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic                      eligible;
    logic [PATTERN_LIMIT-1:0]  eq_vec;
    logic [MATCH_OFS_BITS-1:0] offset;
  } entry_t;

  // Byte idx of the 16-byte pattern held in two 64-bit registers.
  function automatic logic [BYTE_BITS-1:0] pattern_byte(
    input logic [CFG_DATA_BITS-1:0] low,
    input logic [CFG_DATA_BITS-1:0] high,
    input logic [PAT_IDX_BITS-1:0]  idx
  );
    logic [5:0] sel;
    sel = {idx[2:0], 3'b000};
    if (idx[3]) begin
      return high[sel +: BYTE_BITS];
    end
    return low[sel +: BYTE_BITS];
  endfunction

endpackage

`default_nettype wire

/* hdl/bpof_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bpof_byte_if;
  logic                          valid;
  logic                          ready;
  logic [bpof_pkg::BYTE_BITS-1:0] data_byte;
  logic                          file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface bpof_match_if;
  logic                               valid;
  logic                               ready;
  logic [bpof_pkg::MATCH_OFS_BITS-1:0] match_offset;

  modport source (output valid, output match_offset, input ready);
  modport sink   (input valid, input match_offset, output ready);
endinterface

interface bpof_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bpof_pkg::CFG_IDX_BITS-1:0]  index;
  logic [bpof_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/bpof_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpof_front #(
  parameter int PATTERN_MAX = bpof_pkg::PATTERN_MAX_DEFAULT,
  parameter int OFFSET_BITS = bpof_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bpof_byte_if.sink       byte_i,
  bpof_cfg_if.sink        cfg_i,
  output bpof_pkg::entry_t push_entry_o,
  output logic            push_valid_o,
  input  wire logic       push_ready_i
);

  localparam int WinDepth = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int OfsW     = ((OFFSET_BITS > bpof_pkg::MATCH_OFS_BITS) ?
                             OFFSET_BITS : bpof_pkg::MATCH_OFS_BITS) + 1;

  logic [bpof_pkg::CFG_DATA_BITS-1:0] pat_low_q, pat_high_q;
  logic [bpof_pkg::LEN_BITS-1:0]      pat_len_q;

  logic [bpof_pkg::BYTE_BITS-1:0] win_q [WinDepth];
  logic [bpof_pkg::BYTE_BITS-1:0] win_d [WinDepth];
  logic [bpof_pkg::BYTE_BITS-1:0] win_eff [WinDepth];
  logic [OFFSET_BITS-1:0]         cnt_q, cnt_d, cnt_eff;
  logic                           sat_q, sat_d, sat_eff;

  logic                          accept;
  logic [bpof_pkg::LEN_BITS-1:0] len_eff;
  logic [OFFSET_BITS:0]          cnt_plus;
  logic [OfsW-1:0]               ofs_wide;
  logic [bpof_pkg::BYTE_BITS-1:0] cand;
  logic [bpof_pkg::LEN_BITS-1:0]  pidx;
  bpof_pkg::entry_t               entry;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = push_ready_i;
  assign push_valid_o = byte_i.valid;
  assign accept       = byte_i.valid && push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= bpof_pkg::LEN_BITS'(1);
    end else if (cfg_i.valid) begin
      case (bpof_pkg::cfg_reg_e'(cfg_i.index))
        bpof_pkg::CFG_PATTERN_LOW:    pat_low_q  <= cfg_i.data;
        bpof_pkg::CFG_PATTERN_HIGH:   pat_high_q <= cfg_i.data;
        bpof_pkg::CFG_PATTERN_LENGTH: pat_len_q  <= cfg_i.data[bpof_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A file start clears the window and the counter before its byte is used.
  always_comb begin
    sat_eff = byte_i.file_start ? 1'b0 : sat_q;
    cnt_eff = byte_i.file_start ? '0 : cnt_q;
    for (int i = 0; i < WinDepth; i++) begin
      win_eff[i] = byte_i.file_start ? '0 : win_q[i];
    end
    win_d[0] = byte_i.data_byte;
    for (int i = 1; i < WinDepth; i++) begin
      win_d[i] = win_eff[i-1];
    end
    if (sat_eff) begin
      sat_d = 1'b1;
      cnt_d = cnt_eff;
    end else if (&cnt_eff) begin
      sat_d = 1'b1;
      cnt_d = cnt_eff;
    end else begin
      sat_d = 1'b0;
      cnt_d = cnt_eff + OFFSET_BITS'(1);
    end
  end

  // Per-position byte compares; positions beyond the pattern length pass.
  always_comb begin
    len_eff  = (pat_len_q > bpof_pkg::LEN_BITS'(PATTERN_MAX)) ?
               bpof_pkg::LEN_BITS'(PATTERN_MAX) : pat_len_q;
    cnt_plus = {1'b0, cnt_eff} + (OFFSET_BITS+1)'(1);
    ofs_wide = OfsW'(cnt_eff) + OfsW'(1) - OfsW'(len_eff);
    entry.eligible = !sat_eff && (len_eff != '0) &&
                     (cnt_plus >= (OFFSET_BITS+1)'(len_eff));
    entry.offset   = ofs_wide[bpof_pkg::MATCH_OFS_BITS-1:0];
    entry.eq_vec   = '1;
    cand = '0;
    pidx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      cand = (j == 0) ? byte_i.data_byte : win_eff[(j == 0) ? 0 : j-1];
      pidx = len_eff - bpof_pkg::LEN_BITS'(j) - bpof_pkg::LEN_BITS'(1);
      if (bpof_pkg::LEN_BITS'(j) < len_eff) begin
        entry.eq_vec[j] = (cand == bpof_pkg::pattern_byte(pat_low_q, pat_high_q,
                                                          pidx[bpof_pkg::PAT_IDX_BITS-1:0]));
      end
    end
  end

  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sat_q <= 1'b0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      cnt_q <= cnt_d;
      sat_q <= sat_d;
      win_q <= win_d;
    end
  end

  // Once the counter is full, nothing may be reported until a new file.
  a_sat_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sat_q && !byte_i.file_start |-> !entry.eligible)
    else $error("saturated counter let a word through as eligible");

  // A new file leaves exactly one byte counted.
  a_start_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && byte_i.file_start |=> cnt_q == OFFSET_BITS'(1) && !sat_q)
    else $error("file start did not restart the byte counter");

endmodule

`default_nettype wire

/* hdl/bpof_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpof_queue #(
  parameter int DEPTH = bpof_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire bpof_pkg::entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output bpof_pkg::entry_t      pop_entry_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  bpof_pkg::entry_t   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != CntBits'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(DEPTH - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> int'(count_q) == int'($past(count_q)) + int'($past(push)) - int'($past(pop)))
    else $error("queue fill count lost track of pushes and pops");

endmodule

`default_nettype wire

/* hdl/bpof_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpof_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire bpof_pkg::entry_t pop_entry_i,
  bpof_match_if.source          match_o
);

  logic                                out_valid_q, out_valid_d;
  logic [bpof_pkg::MATCH_OFS_BITS-1:0] out_offset_q;
  logic                                hit, pop;

  // All compared positions agree and the file holds enough bytes.
  assign hit         = pop_entry_i.eligible && (&pop_entry_i.eq_vec);
  assign pop_ready_o = !out_valid_q || match_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = hit;
    end else if (match_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && hit) begin
      out_offset_q <= pop_entry_i.offset;
    end
  end

  assign match_o.valid        = out_valid_q;
  assign match_o.match_offset = out_offset_q;

  a_rise_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop) && $past(hit))
    else $error("result appeared without a matching word from the queue");

endmodule

`default_nettype wire

/* hdl/byte_pattern_offset_finder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word                          Handshake
// byte_i    in   data_byte[7:0], file_start    valid/ready
// match_o   out  match_offset[31:0]            valid/ready
// cfg_i     in   index[1:0], data[63:0]        valid/ready, always ready
//
// One byte is taken per cycle while the queue has room; a match is offered on
// match_o after its word has passed the queue memory and the output register.
// The rate is set by the front compare stage, which checks all window positions in
// parallel in the accept cycle, and by the queue: one word a cycle while not full.
// Reset clears the window, the byte counter and the pattern bytes and sets the
// pattern length to 1, all at once, so no clearing pass follows it.
// A stalled match_o fills the queue; byte_i drops ready only when it is full.
module byte_pattern_offset_finder #(
  parameter int PATTERN_MAX = bpof_pkg::PATTERN_MAX_DEFAULT,
  parameter int OFFSET_BITS = bpof_pkg::OFFSET_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = bpof_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bpof_byte_if.sink     byte_i,
  bpof_cfg_if.sink      cfg_i,
  bpof_match_if.source  match_o
);

  // Words between the classifying front and the reporting back.
  bpof_pkg::entry_t push_entry, pop_entry;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;

  // The front owns the pattern registers, the window and the byte counter,
  // and turns each byte into a vector of per-position compare results.
  bpof_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .cfg_i        (cfg_i),
    .push_entry_o (push_entry),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // The queue lets the front keep scanning while a result waits downstream.
  bpof_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The back reduces the compare vector and registers each offset found.
  // Words that hold no match are dropped without using the output slot.
  bpof_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .match_o     (match_o)
  );

endmodule

`default_nettype wire
